@@ rtl/ptta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_pkg: shared types and constants of the pan/tilt target aimer
// Holds the sequencer states, register indexes, fixed-point constants and
// the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package ptta_pkg;

  localparam int PosWidthDef   = 16;
  localparam int IterDef       = 14;
  localparam int CoordWidthDef = 36;
  localparam int AngWidth      = 28;

  localparam logic signed [AngWidth-1:0] AngHalfPi  = 28'sd26353589;
  localparam logic signed [AngWidth-1:0] AngRound   = 28'sd1024;
  localparam int                         AngShift   = 11;
  localparam logic signed [AngWidth-1:0] PanLimit   = 28'sd25736;
  localparam logic signed [14:0]         TiltAtZero = 15'sd1638;
  localparam logic [16:0]                GainKQ16   = 17'd107922;
  localparam logic [8:0]                 MoveNormal = 9'd33;
  localparam logic [8:0]                 MoveZero   = 9'd500;

  localparam logic        RotateEnableRst    = 1'b1;
  localparam logic        SmoothingEnableRst = 1'b1;
  localparam logic [15:0] BlendWeightRst     = 16'd62259;
  localparam logic [14:0] TargetHeightRst    = 15'd512;
  localparam logic [14:0] TiltMinRst         = 15'd0;
  localparam logic [14:0] TiltMaxRst         = 15'd2860;

  typedef enum logic [2:0] {
    REG_ROTATE_ENABLE    = 3'd0,
    REG_SMOOTHING_ENABLE = 3'd1,
    REG_BLEND_WEIGHT     = 3'd2,
    REG_TARGET_HEIGHT    = 3'd3,
    REG_TILT_MIN         = 3'd4,
    REG_TILT_MAX         = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_PAN_GO,
    ST_PAN_WAIT,
    ST_HEIGHT_MUL,
    ST_TILT_GO,
    ST_TILT_WAIT,
    ST_FINISH
  } state_t;

  function automatic logic [AngWidth-1:0] atan_lut(input logic [4:0] idx);
    logic [AngWidth-1:0] val;
    case (idx)
      5'd0:    val = 28'd13176795;
      5'd1:    val = 28'd7778716;
      5'd2:    val = 28'd4110060;
      5'd3:    val = 28'd2086331;
      5'd4:    val = 28'd1047214;
      5'd5:    val = 28'd524117;
      5'd6:    val = 28'd262123;
      5'd7:    val = 28'd131069;
      5'd8:    val = 28'd65536;
      5'd9:    val = 28'd32768;
      5'd10:   val = 28'd16384;
      5'd11:   val = 28'd8192;
      5'd12:   val = 28'd4096;
      5'd13:   val = 28'd2048;
      5'd14:   val = 28'd1024;
      5'd15:   val = 28'd512;
      5'd16:   val = 28'd256;
      5'd17:   val = 28'd128;
      5'd18:   val = 28'd64;
      5'd19:   val = 28'd32;
      5'd20:   val = 28'd16;
      5'd21:   val = 28'd8;
      5'd22:   val = 28'd4;
      5'd23:   val = 28'd2;
      default: val = 28'd0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/pan_tilt_target_aimer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_target_aimer_unit: aims a pan/tilt head at a tracked target
// Smooths position samples and turns them into pan, tilt and move time.
// ----------------------------------------------------------------------------
// Usage: an input item is a position sample (req_type 0) or an aiming tick
// (req_type 1), taken on in_valid and in_ready. A sample produces no result;
// it is copied into the stored position, or blended into it one axis at a
// time with one shared multiplier, keeping the block busy while it blends.
// A tick with rotation enabled produces one result item on the out channel.
// Both angles come from one iterative CORDIC unit run twice, first for the
// bearing and then for the elevation, before the result is loaded. A zero
// stored position skips the CORDIC and goes straight to the finish state.
// The block takes one item at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register; the next item
// is accepted while it waits, but a further result stalls the sequencer
// until out_ready takes the waiting one. Reset clears the stored position
// and loads the register defaults. Registers are written through the APB
// port; write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module pan_tilt_target_aimer_unit #(
  parameter int POSITION_WIDTH    = ptta_pkg::PosWidthDef,
  parameter int CORDIC_ITERATIONS = ptta_pkg::IterDef
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic signed [POSITION_WIDTH-1:0] pos_x,
  input  logic signed [POSITION_WIDTH-1:0] pos_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               pan_cmd,
  output logic signed [14:0]               tilt_cmd,
  output logic [8:0]                       move_time_ms
);
  import ptta_pkg::*;

  localparam int MulWidthB  = (POSITION_WIDTH + 1 > 16) ? POSITION_WIDTH + 1 : 16;
  localparam int ProdWidth  = MulWidthB + 18;
  localparam int SumWidth   = ProdWidth + 1;
  localparam int CoordWidth = ((POSITION_WIDTH + 17 > 32) ? POSITION_WIDTH + 17 : 32) + 3;

  localparam logic signed [SumWidth-1:0] BlendRound = SumWidth'(32'sd32768);
  localparam logic signed [SumWidth-1:0] PosMax =
    SumWidth'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SumWidth-1:0] PosMin = -PosMax - SumWidth'(32'sd1);

  state_t state;
  state_t state_next;

  logic        rotate_enable;
  logic        smoothing_enable;
  logic [15:0] blend_weight;
  logic [14:0] target_height;
  logic [14:0] tilt_min;
  logic [14:0] tilt_max;
  logic        cfg_write;

  logic signed [POSITION_WIDTH-1:0] smoothed_x;
  logic signed [POSITION_WIDTH-1:0] smoothed_y;
  logic signed [POSITION_WIDTH-1:0] new_x;
  logic signed [POSITION_WIDTH-1:0] new_y;
  logic                             axis;
  logic                             zero_dist;
  logic                             pos_zero;
  logic                             in_accept;
  logic                             out_load;

  logic [16:0]                      mul_a;
  logic signed [MulWidthB-1:0]      mul_b;
  logic signed [ProdWidth-1:0]      prod;
  logic signed [POSITION_WIDTH:0]   diff;
  logic signed [POSITION_WIDTH-1:0] blend_old;
  logic signed [POSITION_WIDTH-1:0] blend_new;
  logic signed [SumWidth-1:0]       blend_sum;
  logic signed [SumWidth-1:0]       blend_shr;
  logic signed [POSITION_WIDTH-1:0] blend_sat;

  logic                          cordic_start;
  logic                          cordic_done;
  logic signed [CoordWidth-1:0]  cordic_x0;
  logic signed [CoordWidth-1:0]  cordic_y0;
  logic signed [CoordWidth-1:0]  cordic_mag;
  logic signed [AngWidth-1:0]    cordic_ang;

  logic signed [AngWidth-1:0]    ang_rnd;
  logic signed [AngWidth-1:0]    pan_neg;
  logic signed [AngWidth-1:0]    pan_clamped;
  logic signed [15:0]            pan_q;
  logic signed [AngWidth-1:0]    tilt_lo;
  logic signed [AngWidth-1:0]    tilt_hi;
  logic signed [AngWidth-1:0]    tilt_clamped;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      REG_ROTATE_ENABLE:    prdata = {31'd0, rotate_enable};
      REG_SMOOTHING_ENABLE: prdata = {31'd0, smoothing_enable};
      REG_BLEND_WEIGHT:     prdata = {16'd0, blend_weight};
      REG_TARGET_HEIGHT:    prdata = {17'd0, target_height};
      REG_TILT_MIN:         prdata = {17'd0, tilt_min};
      REG_TILT_MAX:         prdata = {17'd0, tilt_max};
      default:              prdata = 32'd0;
    endcase
  end

  // Shared multiplier and blend arithmetic.
  assign blend_old = axis ? smoothed_y : smoothed_x;
  assign blend_new = axis ? new_y : new_x;
  assign diff      = $signed({blend_new[POSITION_WIDTH-1], blend_new})
                   - $signed({blend_old[POSITION_WIDTH-1], blend_old});
  assign blend_sum = SumWidth'($signed({blend_old, 16'h0000})) + SumWidth'(prod) + BlendRound;
  assign blend_shr = blend_sum >>> 16;
  assign blend_sat = (blend_shr > PosMax) ? POSITION_WIDTH'(PosMax) :
                     (blend_shr < PosMin) ? POSITION_WIDTH'(PosMin) :
                     POSITION_WIDTH'(blend_shr);

  // Angle rounding to units of 2^-13 rad, pan negation and tilt limits.
  assign ang_rnd      = (cordic_ang + AngRound) >>> AngShift;
  assign pan_neg      = -ang_rnd;
  assign pan_clamped  = (pan_neg > PanLimit) ? PanLimit :
                        (pan_neg < -PanLimit) ? -PanLimit : pan_neg;
  assign tilt_lo      = AngWidth'($signed(tilt_min));
  assign tilt_hi      = AngWidth'($signed(tilt_max));
  assign tilt_clamped = (ang_rnd < tilt_lo) ? tilt_lo :
                        (ang_rnd > tilt_hi) ? tilt_hi : ang_rnd;

  assign pos_zero  = (smoothed_x == '0) && (smoothed_y == '0);
  assign in_accept = in_valid && in_ready;

  ptta_cordic #(
    .DataWidth  (CoordWidth),
    .Iterations (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (cordic_x0),
    .y_in  (cordic_y0),
    .done  (cordic_done),
    .mag   (cordic_mag),
    .angle (cordic_ang)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!req_type) begin
            if (smoothing_enable) begin
              state_next = ST_BLEND_MUL;
            end
          end else if (rotate_enable) begin
            state_next = pos_zero ? ST_FINISH : ST_PAN_GO;
          end
        end
      end
      ST_BLEND_MUL:  state_next = ST_BLEND_ADD;
      ST_BLEND_ADD:  state_next = axis ? ST_IDLE : ST_BLEND_MUL;
      ST_PAN_GO:     state_next = ST_PAN_WAIT;
      ST_PAN_WAIT: begin
        if (cordic_done) begin
          state_next = ST_HEIGHT_MUL;
        end
      end
      ST_HEIGHT_MUL: state_next = ST_TILT_GO;
      ST_TILT_GO:    state_next = ST_TILT_WAIT;
      ST_TILT_WAIT: begin
        if (cordic_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready     = (state == ST_IDLE);
    out_load     = (state == ST_FINISH) && (!out_valid || out_ready);
    cordic_start = (state == ST_PAN_GO) || (state == ST_TILT_GO);
    if (state == ST_TILT_GO) begin
      cordic_x0 = cordic_mag;
      cordic_y0 = CoordWidth'(prod);
    end else begin
      cordic_x0 = CoordWidth'($signed({smoothed_x, 16'h0000}));
      cordic_y0 = CoordWidth'($signed({smoothed_y, 16'h0000}));
    end
    if (state == ST_HEIGHT_MUL) begin
      mul_a = GainKQ16;
      mul_b = MulWidthB'($signed({1'b0, target_height}));
    end else begin
      mul_a = 17'd65536 - {1'b0, blend_weight};
      mul_b = MulWidthB'(diff);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      axis             <= 1'b0;
      rotate_enable    <= RotateEnableRst;
      smoothing_enable <= SmoothingEnableRst;
      blend_weight     <= BlendWeightRst;
      target_height    <= TargetHeightRst;
      tilt_min         <= TiltMinRst;
      tilt_max         <= TiltMaxRst;
      smoothed_x       <= '0;
      smoothed_y       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE) begin
        axis <= 1'b0;
      end else if (state == ST_BLEND_ADD) begin
        axis <= 1'b1;
      end
      if (in_accept && !req_type && !smoothing_enable) begin
        smoothed_x <= pos_x;
        smoothed_y <= pos_y;
      end else if (state == ST_BLEND_ADD) begin
        if (axis) begin
          smoothed_y <= blend_sat;
        end else begin
          smoothed_x <= blend_sat;
        end
      end
      if (cfg_write) begin
        case (paddr[4:2])
          REG_ROTATE_ENABLE:    rotate_enable    <= pwdata[0];
          REG_SMOOTHING_ENABLE: smoothing_enable <= pwdata[0];
          REG_BLEND_WEIGHT:     blend_weight     <= pwdata[15:0];
          REG_TARGET_HEIGHT:    target_height    <= pwdata[14:0];
          REG_TILT_MIN:         tilt_min         <= pwdata[14:0];
          REG_TILT_MAX:         tilt_max         <= pwdata[14:0];
          default:              ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_x     <= pos_x;
      new_y     <= pos_y;
      zero_dist <= pos_zero;
    end
    if ((state == ST_BLEND_MUL) || (state == ST_HEIGHT_MUL)) begin
      prod <= $signed({1'b0, mul_a}) * mul_b;
    end
    if ((state == ST_PAN_WAIT) && cordic_done) begin
      pan_q <= 16'(pan_clamped);
    end
    if (out_load) begin
      if (zero_dist) begin
        pan_cmd      <= '0;
        tilt_cmd     <= TiltAtZero;
        move_time_ms <= MoveZero;
      end else begin
        pan_cmd      <= pan_q;
        tilt_cmd     <= 15'(tilt_clamped);
        move_time_ms <= MoveNormal;
      end
    end
  end

  // The CORDIC unit only reports completion while the sequencer waits on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == ST_PAN_WAIT || state == ST_TILT_WAIT))
    else $error("CORDIC completion outside a wait state");

  // A finished result is held back while the previous one is still waiting.
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && !out_ready) |=> (state == ST_FINISH))
    else $error("Result overwrote a waiting item");

  // With ordered limits, a normal result never lies below the lower tilt limit.
  a_tilt_floor: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && move_time_ms == MoveNormal &&
     $signed(tilt_min) <= $signed(tilt_max)) |->
      ($signed(tilt_cmd) >= $signed(tilt_min)))
    else $error("Tilt below lower limit");

endmodule

@@ rtl/ptta_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_cordic: iterative vectoring CORDIC
// One add/shift stage reused for every iteration. Returns the angle of the
// start vector in units of 2^-24 rad and the gain-scaled magnitude.
// ----------------------------------------------------------------------------
module ptta_cordic #(
  parameter int DataWidth  = ptta_pkg::CoordWidthDef,
  parameter int Iterations = ptta_pkg::IterDef
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [DataWidth-1:0]            x_in,
  input  logic signed [DataWidth-1:0]            y_in,
  output logic                                   done,
  output logic signed [DataWidth-1:0]            mag,
  output logic signed [ptta_pkg::AngWidth-1:0]   angle
);
  import ptta_pkg::*;

  localparam int CntWidth = $clog2(Iterations);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(Iterations - 1);

  logic                         busy;
  logic [CntWidth-1:0]          cnt;
  logic signed [DataWidth-1:0]  x;
  logic signed [DataWidth-1:0]  y;
  logic signed [AngWidth-1:0]   z;
  logic signed [DataWidth-1:0]  dx;
  logic signed [DataWidth-1:0]  dy;
  logic signed [AngWidth-1:0]   step_ang;

  assign dx       = y >>> cnt;
  assign dy       = x >>> cnt;
  assign step_ang = $signed(atan_lut(5'(cnt)));
  assign mag      = x;
  assign angle    = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntLast) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= AngHalfPi;
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -AngHalfPi;
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + step_ang;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - step_ang;
      end
    end
  end

endmodule

@@ tb/pan_tilt_target_aimer_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_target_aimer_unit_test: self-checking bench for the target aimer
// A directed table of register writes, samples and ticks is followed by
// randomized phases, each with its own register settings. Every accepted
// item runs through a behavioral model of the smoothing filter and the
// CORDIC aiming path. The aim results that this produces, or a pinned
// result where the table gives one, are queued and compared field by field
// with what the block delivers, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module pan_tilt_target_aimer_unit_test;
  import ptta_pkg::*;

  localparam int CordicSteps = 14;
  localparam longint HalfPiQ24 = 26353589;
  localparam longint PanEdge = 25736;
  localparam longint KGainQ16 = 107922;
  localparam logic signed [14:0] TiltAtRest = 15'sd1638;
  localparam logic [8:0] MsNormal = 9'd33;
  localparam logic [8:0] MsAtRest = 9'd500;
  localparam int SettleCycles = 48;
  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;
  localparam int RandomPhases = 12;
  localparam int ItemsPerPhase = 150;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_kind_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    logic signed [15:0] pan;
    logic signed [14:0] tilt;
    logic [8:0]         mt;
  } aim_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         reg_idx;
    logic [31:0]        value;
    req_kind_t          req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               pinned;
    aim_t               pinned_aim;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] pan_cmd;
  logic signed [14:0] tilt_cmd;
  logic [8:0] move_time_ms;

  logic rot_en;
  logic smooth_en;
  logic [15:0] gain_reg;
  logic [14:0] height_reg;
  logic signed [14:0] tilt_lo;
  logic signed [14:0] tilt_hi;
  logic signed [15:0] track_x;
  logic signed [15:0] track_y;

  aim_t pending_aims[$];
  plan_row_t plan[$];
  logic pinned_now;
  aim_t pinned_aim_now;
  bit calm;
  int mismatch_count = 0;

  pan_tilt_target_aimer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pan_cmd      (pan_cmd),
    .tilt_cmd     (tilt_cmd),
    .move_time_ms (move_time_ms)
  );

  always #6 clk = ~clk;

  function automatic longint arctan_q24(input int i);
    case (i)
      0:       return 13176795;
      1:       return 7778716;
      2:       return 4110060;
      3:       return 2086331;
      4:       return 1047214;
      5:       return 524117;
      6:       return 262123;
      7:       return 131069;
      8:       return 65536;
      9:       return 32768;
      10:      return 16384;
      11:      return 8192;
      12:      return 4096;
      13:      return 2048;
      default: return 0;
    endcase
  endfunction

  function automatic longint vec_angle(input longint xa, input longint ya, output longint mag);
    longint za, t, dx, dy;
    int i;
    za = 0;
    if (xa < 0) begin
      t = xa;
      if (ya >= 0) begin
        xa = ya;
        ya = -t;
        za = HalfPiQ24;
      end else begin
        xa = -ya;
        ya = t;
        za = -HalfPiQ24;
      end
    end
    for (i = 0; i < CordicSteps; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya >= 0) begin
        xa += dx;
        ya -= dy;
        za += arctan_q24(i);
      end else begin
        xa -= dx;
        ya += dy;
        za -= arctan_q24(i);
      end
    end
    mag = xa;
    return za;
  endfunction

  function automatic longint round_angle(input longint z);
    return (z + 1024) >>> 11;
  endfunction

  function automatic longint blend_axis(input longint prior, input longint fresh);
    longint g, acc;
    g = longint'(gain_reg);
    acc = (g * prior + (65536 - g) * fresh + 32768) >>> 16;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return acc;
  endfunction

  function automatic bit aim_predict(input logic tick, input logic signed [15:0] x,
                                     input logic signed [15:0] y, output aim_t res);
    longint bearing, elev, mag, spare, pan, tilt;
    res = '0;
    if (!tick) begin
      if (smooth_en) begin
        track_x = 16'(blend_axis(track_x, x));
        track_y = 16'(blend_axis(track_y, y));
      end else begin
        track_x = x;
        track_y = y;
      end
      return 1'b0;
    end
    if (!rot_en) return 1'b0;
    if (track_x == 0 && track_y == 0) begin
      res.pan = '0;
      res.tilt = TiltAtRest;
      res.mt = MsAtRest;
      return 1'b1;
    end
    bearing = vec_angle(longint'(track_x) * 65536, longint'(track_y) * 65536, mag);
    pan = -round_angle(bearing);
    if (pan > PanEdge) pan = PanEdge;
    if (pan < -PanEdge) pan = -PanEdge;
    elev = vec_angle(mag, longint'(height_reg) * KGainQ16, spare);
    tilt = round_angle(elev);
    if (tilt < longint'(tilt_lo)) tilt = longint'(tilt_lo);
    else if (tilt > longint'(tilt_hi)) tilt = longint'(tilt_hi);
    res.pan = 16'(pan);
    res.tilt = 15'(tilt);
    res.mt = MsNormal;
    return 1'b1;
  endfunction

  task automatic model_reset();
    rot_en = 1'b1;
    smooth_en = 1'b1;
    gain_reg = 16'd62259;
    height_reg = 15'd512;
    tilt_lo = 15'sd0;
    tilt_hi = 15'sd2860;
    track_x = '0;
    track_y = '0;
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(2, 1);
    if (r < 90) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_aims.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROTATE_ENABLE:    rot_en = val[0];
      REG_SMOOTHING_ENABLE: smooth_en = val[0];
      REG_BLEND_WEIGHT:     gain_reg = val[15:0];
      REG_TARGET_HEIGHT:    height_reg = val[14:0];
      REG_TILT_MIN:         tilt_lo = val[14:0];
      REG_TILT_MAX:         tilt_hi = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input req_kind_t kind, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic pinned, input aim_t aim);
    int gap;
    gap = (calm || $urandom_range(99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= kind;
    pos_x <= x;
    pos_y <= y;
    pinned_now <= pinned;
    pinned_aim_now <= aim;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = val;
    plan.push_back(r);
  endtask

  task automatic add_item(input req_kind_t kind, input logic signed [15:0] x,
                          input logic signed [15:0] y);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.req = kind;
    r.x = x;
    r.y = y;
    plan.push_back(r);
  endtask

  task automatic add_pinned(input logic signed [15:0] pan, input logic signed [14:0] tilt,
                            input logic [8:0] mt);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.req = REQ_TICK;
    r.pinned = 1'b1;
    r.pinned_aim = {pan, tilt, mt};
    plan.push_back(r);
  endtask

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom);
    if (r < 80) return 16'(int'($urandom_range(255)) - 128);
    if (r < 88) return 16'sd0;
    if (r < 94) return 16'sh8000;
    return 16'sh7fff;
  endfunction

  function automatic int pick_tilt();
    int r;
    r = $urandom_range(99);
    if (r < 10) return -12868;
    if (r < 20) return 12868;
    return int'($urandom_range(25736)) - 12868;
  endfunction

  task automatic randomize_config();
    int lo, hi, t, r, height, gain;
    r = $urandom_range(99);
    gain = (r < 10) ? 0 : (r < 20) ? 65535 : int'($urandom_range(65535));
    r = $urandom_range(99);
    height = (r < 10) ? 0 : (r < 20) ? 32767 :
             (r < 60) ? int'($urandom_range(2047)) : int'($urandom_range(32767));
    lo = pick_tilt();
    hi = pick_tilt();
    if (lo > hi && $urandom_range(3) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    write_reg(REG_ROTATE_ENABLE, ($urandom_range(5) != 0));
    write_reg(REG_SMOOTHING_ENABLE, $urandom_range(1));
    write_reg(REG_BLEND_WEIGHT, gain);
    write_reg(REG_TARGET_HEIGHT, height);
    write_reg(REG_TILT_MIN, lo);
    write_reg(REG_TILT_MAX, hi);
    if ($urandom_range(3) == 0) write_reg(RegSpareA, $urandom);
  endtask

  task automatic send_random();
    logic signed [15:0] x, y;
    req_kind_t kind;
    int r;
    kind = ($urandom_range(99) < 40) ? REQ_TICK : REQ_SAMPLE;
    r = $urandom_range(99);
    if (r < 8) begin
      x = -16'($urandom_range(32768, 1));
      y = '0;
    end else if (r < 13) begin
      x = '0;
      y = '0;
    end else begin
      x = pick_coord();
      y = pick_coord();
    end
    send_item(kind, x, y, 1'b0, '0);
  endtask

  task automatic build_plan();
    add_pinned(16'sd0, TiltAtRest, MsAtRest);
    add_item(REQ_SAMPLE, 16'sh7fff, 16'sh8000);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_item(REQ_SAMPLE, 16'sh8000, 16'sh7fff);
    add_item(REQ_TICK, -16'sd1, -16'sd1);
    add_write(REG_SMOOTHING_ENABLE, 0);
    add_write(REG_TILT_MIN, 12868);
    add_write(REG_TILT_MAX, 12868);
    add_item(REQ_SAMPLE, -16'sd1000, 16'sd0);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_item(REQ_SAMPLE, 16'sd0, 16'sd0);
    add_pinned(16'sd0, TiltAtRest, MsAtRest);
    add_item(REQ_SAMPLE, 16'sh7fff, 16'sh7fff);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_TILT_MIN, -12868);
    add_write(REG_TARGET_HEIGHT, 32767);
    add_item(REQ_SAMPLE, 16'sh8000, 16'sh8000);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_item(REQ_SAMPLE, 16'sd1, 16'sd0);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_TARGET_HEIGHT, 0);
    add_item(REQ_SAMPLE, 16'sd0, -16'sd1);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_TARGET_HEIGHT, 512);
    add_write(REG_TILT_MIN, 2000);
    add_write(REG_TILT_MAX, -2000);
    add_item(REQ_SAMPLE, 16'sd3000, 16'sd500);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_ROTATE_ENABLE, 0);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_item(REQ_SAMPLE, 16'sd700, -16'sd300);
    add_write(REG_ROTATE_ENABLE, 1);
    add_write(RegSpareA, 0);
    add_write(RegSpareB, 32'hffff_ffff);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_SMOOTHING_ENABLE, 1);
    add_write(REG_BLEND_WEIGHT, 0);
    add_item(REQ_SAMPLE, 16'sh8000, 16'sh7fff);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
    add_write(REG_BLEND_WEIGHT, 65535);
    add_item(REQ_SAMPLE, 16'sh7fff, 16'sh8000);
    add_item(REQ_TICK, 16'sd0, 16'sd0);
  endtask

  always @(posedge clk) begin : watch
    aim_t want;
    aim_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (aim_predict(req_type, pos_x, pos_y, want))
          pending_aims.push_back(pinned_now ? pinned_aim_now : want);
      end
      if (out_valid && out_ready) begin
        got = {pan_cmd, tilt_cmd, move_time_ms};
        if (pending_aims.size() == 0) begin
          note_mismatch($sformatf("result pan %0d tilt %0d move %0d with none pending",
                                  got.pan, got.tilt, got.mt));
        end else begin
          want = pending_aims.pop_front();
          if (got.pan != want.pan)
            note_mismatch($sformatf("pan_cmd %0d, expected %0d", got.pan, want.pan));
          if (got.tilt != want.tilt)
            note_mismatch($sformatf("tilt_cmd %0d, expected %0d", got.tilt, want.tilt));
          if (got.mt != want.mt)
            note_mismatch($sformatf("move_time_ms %0d, expected %0d", got.mt, want.mt));
        end
      end
    end
  end

  initial begin : result_side
    int hold, stall_pct, span;
    hold = 0;
    stall_pct = 0;
    span = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
        span = 300;
      end
      span--;
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < stall_pct) hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    int i, p, n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pinned_now = 1'b0;
    pinned_aim_now = '0;
    calm = 1'b0;
    model_reset();
    build_plan();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) write_reg(row.reg_idx, row.value);
      else send_item(row.req, row.x, row.y, row.pinned, row.pinned_aim);
    end
    for (p = 0; p < RandomPhases; p++) begin
      randomize_config();
      calm = ($urandom_range(3) == 0);
      for (n = 0; n < ItemsPerPhase; n++) send_random();
    end
    wait_idle();
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
